FILE: rtl/hgrc_pkg.sv
// hgrc_pkg: shared types and constants of the horizontal grid ray caster.
// No dependencies.
`default_nettype none
package hgrc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PLAYER_X    = 2'd0;
  localparam logic [1:0] CFG_PLAYER_Y    = 2'd1;
  localparam logic [1:0] CFG_MAP_COLUMNS = 2'd2;
  localparam logic [1:0] CFG_MAP_ROWS    = 2'd3;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // datapath widths, sized for the largest map and cell
  localparam int COORD_W = 48;   // signed Q43.4 positions while walking
  localparam int GY_W    = 12;   // signed cell row while walking
  localparam int RC_W    = 21;   // in-map coordinate fed to the cell divider
  localparam int DIV_W   = 48;   // dividend and quotient of the serial divider
  localparam int DSR_W   = 32;   // divisor of the serial divider
  localparam int CX_W    = 34;   // CORDIC x and y
  localparam int CZ_W    = 20;   // CORDIC residual angle
  localparam int SQ_W    = 42;   // sum of squares and root datapath
  localparam int EXT_W   = 9;    // cell row/column widened for range checks

  localparam logic [23:0] TAN_MAX = 24'hFFFFFF;
  localparam logic [12:0] DIST_MAX = 13'd8191;

  typedef logic signed [COORD_W-1:0] coord_t;

  // arctangent steps of the 16-step CORDIC, in 65536-per-turn units
  function automatic logic signed [CZ_W-1:0] cordic_step(input logic [3:0] k);
    logic signed [CZ_W-1:0] s;
    case (k)
      4'd0:    s = 20'sd8192;
      4'd1:    s = 20'sd4836;
      4'd2:    s = 20'sd2555;
      4'd3:    s = 20'sd1297;
      4'd4:    s = 20'sd651;
      4'd5:    s = 20'sd326;
      4'd6:    s = 20'sd163;
      4'd7:    s = 20'sd81;
      4'd8:    s = 20'sd41;
      4'd9:    s = 20'sd20;
      4'd10:   s = 20'sd10;
      4'd11:   s = 20'sd5;
      4'd12:   s = 20'sd3;
      4'd13:   s = 20'sd1;
      4'd14:   s = 20'sd1;
      default: s = 20'sd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/horizontal_grid_ray_cast.sv
// horizontal_grid_ray_cast: wall map store and horizontal grid line ray caster.
// Depends on hgrc_pkg.
//
// The block holds a MAP_SIDE x MAP_SIDE one-bit wall map, kept as one memory
// word per map row with a valid flip-flop per row, so reset clears the map at
// once with no clearing pass. A write beat (operation 0) updates one cell by a
// read-modify-write of its row. A cast beat (operation 1) returns one distance
// beat. One item is in work at a time; in_stall is high until the item is
// finished, and a finished distance waits in the output register while the
// next beat is taken. A cast runs the CORDIC, then the serial divider (one
// quotient bit a cycle) for the tangent, the first x offset and the x step,
// then one map row read per crossed cell row, then the bit-pair square root.
// Vertical rays skip the tangent work; horizontal rays skip straight to a
// distance of zero. Configuration writes are taken at any cycle but must only
// be issued while idle.
`default_nettype none
module horizontal_grid_ray_cast
  import hgrc_pkg::*;
#(
  parameter int MAP_SIDE        = 64,
  parameter int CELL_PIXELS     = 64,
  parameter int TAN_TABLE_DEPTH = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_cell_row,
  input  wire logic [5:0]  in_cell_col,
  input  wire logic        in_cell_is_wall,
  input  wire logic [15:0] in_ray_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [12:0]      out_wall_distance
);

  localparam int CELL  = CELL_PIXELS * 16;            // cell size in Q12.4 units
  localparam int IDX_W = $clog2(MAP_SIDE);
  localparam longint unsigned RECIP = (64'd1 << 32) / CELL;
  localparam longint unsigned RECIP_T = (64'd1 << 32) / TAN_TABLE_DEPTH;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WR_RD  = 5'd1;
  localparam logic [4:0] S_WR_WB  = 5'd2;
  localparam logic [4:0] S_CAST0  = 5'd3;
  localparam logic [4:0] S_PYM    = 5'd4;
  localparam logic [4:0] S_PYF    = 5'd5;
  localparam logic [4:0] S_DIV    = 5'd6;
  localparam logic [4:0] S_CZ     = 5'd7;
  localparam logic [4:0] S_CORD   = 5'd8;
  localparam logic [4:0] S_TANCHK = 5'd9;
  localparam logic [4:0] S_TANQ   = 5'd10;
  localparam logic [4:0] S_TQCHK  = 5'd11;
  localparam logic [4:0] S_FIRSTQ = 5'd12;
  localparam logic [4:0] S_STEPQ  = 5'd13;
  localparam logic [4:0] S_PLACE  = 5'd14;
  localparam logic [4:0] S_PXM    = 5'd15;
  localparam logic [4:0] S_PXF    = 5'd16;
  localparam logic [4:0] S_CHK    = 5'd17;
  localparam logic [4:0] S_STEP   = 5'd18;
  localparam logic [4:0] S_CLAMP  = 5'd19;
  localparam logic [4:0] S_DIST   = 5'd20;
  localparam logic [4:0] S_SQX    = 5'd21;
  localparam logic [4:0] S_SQY    = 5'd22;
  localparam logic [4:0] S_SQRT   = 5'd23;
  localparam logic [4:0] S_OUT    = 5'd24;
  localparam logic [4:0] S_DONE   = 5'd25;
  localparam logic [4:0] S_ZM     = 5'd26;

  // ---------------------------------------------------------------- registers
  logic [15:0] player_x_r, player_y_r;
  logic [6:0]  map_columns_r, map_rows_r;

  logic [4:0]  state_r, div_ret_r;
  logic        out_valid_r;
  logic [12:0] out_data_r, res_r;

  // write item
  logic [IDX_W-1:0] wr_row_r, wr_col_r;
  logic             wr_wall_r;

  // cast item
  logic [15:0]  ang_r;
  logic         up_r, right_r, first_chk_r;
  logic [14:0]  ref_r;
  logic [16:0]  idx_r;
  coord_t       ptx_r, pty_r, sx_r, first_r, step_r;
  logic signed [GY_W-1:0] gy_r;
  logic [IDX_W-1:0] gx_r;
  logic [23:0]  tq_r;

  // cell divider (multiply by reciprocal, one correction)
  logic [RC_W-1:0] rc_v_r, rc_q0_r;

  // table angle divider (multiply by reciprocal, one correction)
  logic [15:0] zq0_r;

  // serial divider
  logic [DSR_W-1:0] div_rem_r, div_dsr_r;
  logic [DIV_W-1:0] div_quo_r;
  logic [5:0]       div_cnt_r;

  // CORDIC
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [CZ_W-1:0] cz_r;
  logic [3:0]             ck_r;

  // distance
  logic [RC_W-1:0] ax_r, ay_r;
  logic [SQ_W-1:0] acc_r, sres_r, sbit_r;

  // wall map: one word per row, row valid bits stand for the cleared reset state
  logic [MAP_SIDE-1:0] map_mem [MAP_SIDE];
  logic [MAP_SIDE-1:0] mem_rdata_r, mem_wdata;
  logic [MAP_SIDE-1:0] row_valid_r;
  logic [IDX_W-1:0]    mem_raddr;
  logic                mem_we;

  // ------------------------------------------------------------- comb helpers
  logic [EXT_W-1:0] cols_eff, rows_eff, in_row_ext, in_col_ext;
  coord_t           lim_x, lim_y, px_s, py_s;
  logic             in_accept;

  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_wall_distance = out_data_r;

  assign in_row_ext = {3'b000, in_cell_row};
  assign in_col_ext = {3'b000, in_cell_col};
  assign cols_eff = ({2'b00, map_columns_r} > EXT_W'(MAP_SIDE)) ?
                    EXT_W'(MAP_SIDE) : {2'b00, map_columns_r};
  assign rows_eff = ({2'b00, map_rows_r} > EXT_W'(MAP_SIDE)) ?
                    EXT_W'(MAP_SIDE) : {2'b00, map_rows_r};
  assign lim_x = $signed(COORD_W'(cols_eff) * COORD_W'(CELL));
  assign lim_y = $signed(COORD_W'(rows_eff) * COORD_W'(CELL));
  assign px_s  = $signed({32'd0, player_x_r});
  assign py_s  = $signed({32'd0, player_y_r});

  // cell divider
  logic [RC_W+31:0] rc_prod;
  logic [RC_W-1:0]  rc_rem, rc_q;
  assign rc_prod = (RC_W+32)'(rc_v_r) * (RC_W+32)'(RECIP);
  assign rc_rem  = rc_v_r - RC_W'(rc_q0_r * RC_W'(CELL));
  assign rc_q    = (rc_rem >= RC_W'(CELL)) ? rc_q0_r + 1'b1 : rc_q0_r;

  // table angle: (index << 14) / TAN_TABLE_DEPTH
  logic [30:0] z_num, z_rem;
  logic [63:0] z_prod;
  logic [15:0] z_q;
  assign z_num  = {idx_r, 14'd0};
  assign z_prod = 64'(z_num) * 64'(RECIP_T);
  assign z_rem  = z_num - 31'(32'(zq0_r) * 32'(TAN_TABLE_DEPTH));
  assign z_q    = (z_rem >= 31'(TAN_TABLE_DEPTH)) ? zq0_r + 1'b1 : zq0_r;

  // serial divider step
  logic [DSR_W:0]   div_sh, div_sub;
  logic             div_ge;
  assign div_sh  = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge  = div_sh >= {1'b0, div_dsr_r};
  assign div_sub = div_sh - {1'b0, div_dsr_r};

  // CORDIC step
  function automatic logic signed [CX_W-1:0] sh_tz(input logic signed [CX_W-1:0] v,
                                                   input logic [3:0] k);
    logic signed [CX_W-1:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> k;
    return (v < 0) ? -m : m;
  endfunction

  logic signed [CX_W-1:0] cxs, cys;
  assign cxs = sh_tz(cx_r, ck_r);
  assign cys = sh_tz(cy_r, ck_r);

  // tangent saturation and first x offset numerator
  logic [23:0] tq_sat;
  coord_t      ady_c;
  assign tq_sat = (div_quo_r > DIV_W'(TAN_MAX)) ? TAN_MAX : div_quo_r[23:0];
  assign ady_c  = (py_s > pty_r) ? py_s - pty_r : pty_r - py_s;

  // walk step
  coord_t ptx_n, pty_n, ptx_place;
  logic signed [GY_W-1:0] gy_n, rows_s;
  logic step_out, place_out, first_out, wall_bit;
  assign rows_s   = $signed({3'b000, rows_eff});
  assign ptx_n    = ptx_r + sx_r;
  assign pty_n    = up_r ? pty_r - COORD_W'(CELL) : pty_r + COORD_W'(CELL);
  assign gy_n     = up_r ? gy_r - 1'b1 : gy_r + 1'b1;
  assign step_out = (gy_n < 0) || (gy_n >= rows_s) || (ptx_n < 0) || (ptx_n >= lim_x);
  assign ptx_place = right_r ? px_s + first_r : px_s - first_r;
  assign place_out = (gy_r < 0) || (gy_r >= rows_s) || (ptx_place < 0) ||
                     (ptx_place >= lim_x);
  assign first_out = (ptx_n < 0) || (ptx_n >= lim_x);
  assign wall_bit  = row_valid_r[gy_r[IDX_W-1:0]] & mem_rdata_r[gx_r];

  // distance
  coord_t dx_c, dy_c;
  logic [SQ_W-1:0] sq_t;
  assign dx_c = (px_s > ptx_r) ? px_s - ptx_r : ptx_r - px_s;
  assign dy_c = (py_s > pty_r) ? py_s - pty_r : pty_r - py_s;
  assign sq_t = sres_r + sbit_r;

  // ------------------------------------------------------------------- memory
  always_comb begin
    mem_raddr = (state_r == S_WR_RD) ? wr_row_r : gy_r[IDX_W-1:0];
    mem_we    = (state_r == S_WR_WB);
    mem_wdata = row_valid_r[wr_row_r] ? mem_rdata_r : '0;
    mem_wdata[wr_col_r] = wr_wall_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_row_r] <= mem_wdata;
    end
    mem_rdata_r <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (mem_we) begin
      row_valid_r[wr_row_r] <= 1'b1;
    end
  end

  // ------------------------------------------------------------ configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r    <= '0;
      player_y_r    <= '0;
      map_columns_r <= 7'd64;
      map_rows_r    <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLAYER_X:    player_x_r    <= cfg_data;
        CFG_PLAYER_Y:    player_y_r    <= cfg_data;
        CFG_MAP_COLUMNS: map_columns_r <= cfg_data[6:0];
        CFG_MAP_ROWS:    map_rows_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE owns the output register in its own cycle
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_operation == OP_WRITE) begin
              wr_row_r  <= in_row_ext[IDX_W-1:0];
              wr_col_r  <= in_col_ext[IDX_W-1:0];
              wr_wall_r <= in_cell_is_wall;
              // cells beyond the map side are dropped
              if (in_row_ext < EXT_W'(MAP_SIDE) && in_col_ext < EXT_W'(MAP_SIDE)) begin
                state_r <= S_WR_RD;
              end
            end else begin
              ang_r   <= in_ray_angle;
              state_r <= S_CAST0;
            end
          end
        end
        S_WR_RD: state_r <= S_WR_WB;
        S_WR_WB: state_r <= S_IDLE;
        S_CAST0: begin
          up_r    <= ang_r < 16'd32768;
          right_r <= (ang_r < 16'd16384) || (ang_r > 16'd49152);
          if (ang_r[14:0] > 15'd16384) begin
            ref_r <= 15'(16'd32768 - {1'b0, ang_r[14:0]});
            idx_r <= 17'((32'(16'd32768 - {1'b0, ang_r[14:0]}) *
                          32'(TAN_TABLE_DEPTH)) >> 14);
          end else begin
            ref_r <= ang_r[14:0];
            idx_r <= 17'((32'(ang_r[14:0]) * 32'(TAN_TABLE_DEPTH)) >> 14);
          end
          rc_v_r <= RC_W'(player_y_r);
          if (ang_r[14:0] == 15'd0) begin
            // horizontal ray
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_PYM;
          end
        end
        S_PYM: begin
          rc_q0_r <= rc_prod[RC_W+31:32];
          state_r <= S_PYF;
        end
        S_PYF: begin
          pty_r <= $signed(COORD_W'(rc_q) * COORD_W'(CELL)) +
                   (up_r ? -COORD_W'(16) : COORD_W'(CELL));
          gy_r  <= up_r ? $signed(GY_W'(rc_q)) - 1'b1 : $signed(GY_W'(rc_q)) + 1'b1;
          if (ref_r == 15'd16384) begin
            // vertical ray: no x travel
            first_r <= '0;
            step_r  <= '0;
            state_r <= S_PLACE;
          end else begin
            state_r <= S_ZM;
          end
        end
        S_ZM: begin
          zq0_r   <= z_prod[47:32];
          state_r <= S_CZ;
        end
        S_DIV: begin
          div_rem_r <= div_ge ? div_sub[DSR_W-1:0] : div_sh[DSR_W-1:0];
          div_quo_r <= {div_quo_r[DIV_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == 6'(DIV_W - 1)) begin
            state_r <= div_ret_r;
          end
        end
        S_CZ: begin
          cz_r    <= $signed(CZ_W'(z_q));
          cx_r    <= CX_W'(64'd1 << 30);
          cy_r    <= '0;
          ck_r    <= '0;
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - cys;
            cy_r <= cy_r + cxs;
            cz_r <= cz_r - cordic_step(ck_r);
          end else begin
            cx_r <= cx_r + cys;
            cy_r <= cy_r - cxs;
            cz_r <= cz_r + cordic_step(ck_r);
          end
          ck_r <= ck_r + 1'b1;
          if (ck_r == 4'd15) begin
            state_r <= S_TANCHK;
          end
        end
        S_TANCHK: begin
          if (cy_r < 0) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else if (cx_r <= 0) begin
            tq_r    <= TAN_MAX;
            state_r <= S_TQCHK;
          end else begin
            div_rem_r <= '0;
            div_quo_r <= {1'b0, cy_r[30:0], 16'd0};
            div_dsr_r <= cx_r[DSR_W-1:0];
            div_cnt_r <= '0;
            div_ret_r <= S_TANQ;
            state_r   <= S_DIV;
          end
        end
        S_TANQ: begin
          tq_r    <= tq_sat;
          state_r <= S_TQCHK;
        end
        S_TQCHK: begin
          if (tq_r == '0) begin
            // too near horizontal
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            div_rem_r <= '0;
            div_quo_r <= {ady_c[31:0], 16'd0};
            div_dsr_r <= {8'd0, tq_r};
            div_cnt_r <= '0;
            div_ret_r <= S_FIRSTQ;
            state_r   <= S_DIV;
          end
        end
        S_FIRSTQ: begin
          first_r   <= $signed({1'b0, div_quo_r[DIV_W-2:0]});
          div_rem_r <= '0;
          div_quo_r <= DIV_W'(64'(CELL) << 16);
          div_dsr_r <= {8'd0, tq_r};
          div_cnt_r <= '0;
          div_ret_r <= S_STEPQ;
          state_r   <= S_DIV;
        end
        S_STEPQ: begin
          step_r  <= $signed({1'b0, div_quo_r[DIV_W-2:0]});
          state_r <= S_PLACE;
        end
        S_PLACE: begin
          ptx_r       <= ptx_place;
          sx_r        <= right_r ? step_r : -step_r;
          rc_v_r      <= ptx_place[RC_W-1:0];
          first_chk_r <= 1'b1;
          if (place_out) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_PXM;
          end
        end
        S_PXM: begin
          rc_q0_r <= rc_prod[RC_W+31:32];
          state_r <= S_PXF;
        end
        S_PXF: begin
          // map row gy is read this cycle
          gx_r    <= rc_q[IDX_W-1:0];
          state_r <= S_CHK;
        end
        S_CHK: begin
          first_chk_r <= 1'b0;
          if (first_chk_r) begin
            if (wall_bit) begin
              state_r <= S_DIST;           // wall at the first crossing, unclamped
            end else if (first_out) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_STEP;
            end
          end else if (wall_bit) begin
            state_r <= S_CLAMP;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          ptx_r  <= ptx_n;
          pty_r  <= pty_n;
          gy_r   <= gy_n;
          rc_v_r <= ptx_n[RC_W-1:0];
          state_r <= step_out ? S_CLAMP : S_PXM;
        end
        S_CLAMP: begin
          if (pty_r > lim_y - COORD_W'(16)) begin
            pty_r <= lim_y - COORD_W'(16);
          end else if (pty_r < 0) begin
            pty_r <= '0;
          end
          if (ptx_r > lim_x - COORD_W'(16)) begin
            ptx_r <= lim_x - COORD_W'(16);
          end else if (ptx_r < 0) begin
            ptx_r <= '0;
          end
          state_r <= S_DIST;
        end
        S_DIST: begin
          ax_r    <= dx_c[RC_W-1:0];
          ay_r    <= dy_c[RC_W-1:0];
          state_r <= S_SQX;
        end
        S_SQX: begin
          acc_r   <= SQ_W'(ax_r) * SQ_W'(ax_r);
          state_r <= S_SQY;
        end
        S_SQY: begin
          acc_r   <= acc_r + SQ_W'(ay_r) * SQ_W'(ay_r);
          sres_r  <= '0;
          sbit_r  <= SQ_W'(64'd1 << 40);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (acc_r >= sq_t) begin
            acc_r  <= acc_r - sq_t;
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          if (sbit_r[0]) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          res_r   <= ((sres_r >> 4) > SQ_W'(DIST_MAX)) ? DIST_MAX : sres_r[16:4];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
